[hdl/bbcd_pkg.sv]
// ----------------------------------------------------------------------------
// Block buffer cache directory package
// Shared constants, opcodes, status codes, back-end states and queue entry type.
// ----------------------------------------------------------------------------
package bbcd_pkg;

	localparam int CacheSlotsDef = 16;
	localparam int BlockBitsDef  = 16;
	localparam int RefMax        = 255;
	localparam int QueueDepth    = 2;

	typedef enum logic [2:0] {
		OP_GET      = 3'd0,
		OP_RELEASE  = 3'd1,
		OP_DIRTY    = 3'd2,
		OP_SYNC     = 3'd3,
		OP_DISCARD  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_HIT       = 3'd0,
		ST_MISS      = 3'd1,
		ST_BUSY      = 3'd2,
		ST_BAD       = 3'd3,
		ST_WRITEBACK = 3'd4,
		ST_DONE      = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_EXEC,
		BK_SCAN,
		BK_SHIFT,
		BK_EMIT
	} bk_state_t;

	// classified command handed from front to back
	typedef struct packed {
		logic [2:0]  op;
		logic [15:0] block_number;
		logic [3:0]  slot;
		logic        op_known;
	} cmd_t;

endpackage

[hdl/block_buffer_cache_directory.sv]
// ----------------------------------------------------------------------------
// Block buffer cache directory
// Slot lookup, FIFO replacement, release, mark dirty, sync and discard.
// ----------------------------------------------------------------------------
// channel | dir | contents
// s_axis  | in  | request word: opcode, block_number, slot
// m_axis  | out | result word: status, slot_out, writeback, fill, tlast
// Get hit or free-slot miss, release, mark dirty, unknown opcode: the back end
// takes the command from the queue, executes it and registers the result word.
// Get miss with full cache and discard of a valid slot: plus a scan over the order
// entries and, once the victim or discarded slot is found, a shift of those behind it.
// Sync: take, execute, then a scan over every order entry; the done word comes last.
// Reset clears all slots at once; no clearing pass. Output stalls hold the back end.
module block_buffer_cache_directory #(
	parameter int CACHE_SLOTS = bbcd_pkg::CacheSlotsDef,
	parameter int BLOCK_BITS  = bbcd_pkg::BlockBitsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // opcode[2:0], block_number[18:3], slot[22:19]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // status[2:0], slot_out[6:3], writeback_needed[7],
	                                   // writeback_block[23:8], fill_needed[24]
	output logic        m_axis_tlast
);

	bbcd_pkg::cmd_t cmd;
	logic           cmd_valid, cmd_ready;
	logic [2:0]     status;
	logic [3:0]     slot_out;
	logic           wb, fl;
	logic [15:0]    wbb;

	bbcd_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.op(s_axis_tdata[2:0]), .block_number(s_axis_tdata[18:3]),
		.slot(s_axis_tdata[22:19]),
		.cmd_valid, .cmd_ready, .cmd
	);

	bbcd_back #(.CACHE_SLOTS(CACHE_SLOTS), .BLOCK_BITS(BLOCK_BITS)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.status, .slot_out, .writeback_needed(wb), .writeback_block(wbb),
		.fill_needed(fl), .last(m_axis_tlast)
	);

	assign m_axis_tdata = {7'd0, fl, wbb, wb, slot_out, status};

`ifndef NO_ASSERTIONS
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] == 3'(bbcd_pkg::ST_DONE) |-> m_axis_tlast)
		else $error("done word without tlast");
	a_wb_notlast: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] == 3'(bbcd_pkg::ST_WRITEBACK) |-> !m_axis_tlast)
		else $error("sync writeback word marked last");
	a_fill_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[24] |-> m_axis_tdata[2:0] == 3'(bbcd_pkg::ST_MISS))
		else $error("fill without miss");
`endif

endmodule

[hdl/bbcd_front.sv]
// ----------------------------------------------------------------------------
// Block buffer cache directory front end
// Accepts request words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module bbcd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [2:0]       op,
	input  logic [15:0]      block_number,
	input  logic [3:0]       slot,
	output logic             cmd_valid,
	input  logic             cmd_ready,
	output bbcd_pkg::cmd_t   cmd
);

	localparam int D = bbcd_pkg::QueueDepth;

	bbcd_pkg::cmd_t mem_q [D];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	logic           push, pop;
	bbcd_pkg::cmd_t nxt;

	assign in_ready  = (cnt_q != 2'(D));
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = mem_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_comb begin
		nxt.op           = op;
		nxt.block_number = block_number;
		nxt.slot         = slot;
		nxt.op_known     = (op <= 3'(bbcd_pkg::OP_DISCARD));
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

[hdl/bbcd_back.sv]
// ----------------------------------------------------------------------------
// Block buffer cache directory back end
// Holds slot state and allocation order; executes one command at a time.
// ----------------------------------------------------------------------------
module bbcd_back #(
	parameter int CACHE_SLOTS = bbcd_pkg::CacheSlotsDef,
	parameter int BLOCK_BITS  = bbcd_pkg::BlockBitsDef
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  bbcd_pkg::cmd_t cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [2:0]     status,
	output logic [3:0]     slot_out,
	output logic           writeback_needed,
	output logic [15:0]    writeback_block,
	output logic           fill_needed,
	output logic           last
);

	localparam int SW = $clog2(CACHE_SLOTS);
	localparam int CW = $clog2(CACHE_SLOTS + 1);

	logic [CACHE_SLOTS-1:0] valid_q, dirty_q;
	logic [BLOCK_BITS-1:0]  block_q [CACHE_SLOTS];
	logic [7:0]             ref_q   [CACHE_SLOTS];
	logic [SW-1:0]          order_q [CACHE_SLOTS];
	logic [CW-1:0]          used_q;

	bbcd_pkg::bk_state_t state_q, state_d;
	bbcd_pkg::cmd_t      cmd_q;
	logic [CW-1:0]       idx_q;
	logic [SW-1:0]       rm_slot_q;
	logic                sync_q;

	// output register
	logic        ov_q;
	logic [2:0]  st_q;
	logic [3:0]  so_q;
	logic        wb_q, fl_q, la_q;
	logic [15:0] wbb_q;

	assign out_valid        = ov_q;
	assign status           = st_q;
	assign slot_out         = so_q;
	assign writeback_needed = wb_q;
	assign writeback_block  = wbb_q;
	assign fill_needed      = fl_q;
	assign last             = la_q;

	logic out_free;
	assign out_free  = !ov_q || out_ready;
	assign cmd_ready = (state_q == bbcd_pkg::BK_IDLE);

	// associative match and free-slot search
	logic                  hit, has_free;
	logic [SW-1:0]         hit_idx, free_idx;
	logic [BLOCK_BITS-1:0] blk;
	logic                  s_ok;
	logic [SW-1:0]         s_idx;

	assign blk   = BLOCK_BITS'(cmd_q.block_number);
	assign s_idx = SW'(cmd_q.slot);
	assign s_ok  = ({28'd0, cmd_q.slot} < CACHE_SLOTS) && valid_q[s_idx];

	always_comb begin
		hit = 1'b0; hit_idx = '0; has_free = 1'b0; free_idx = '0;
		for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
			if (valid_q[i] && block_q[i] == blk) begin hit = 1'b1; hit_idx = SW'(i); end
			if (!valid_q[i]) begin has_free = 1'b1; free_idx = SW'(i); end
		end
	end

	// current scan element
	logic [SW-1:0] cur;
	logic          scan_end;
	assign cur      = order_q[idx_q[SW-1:0]];
	assign scan_end = (idx_q >= used_q);

	// a result word is loaded into the output register this cycle
	logic fire;
	always_comb begin
		fire = 1'b0;
		if (out_free) begin
			if (state_q == bbcd_pkg::BK_EXEC) begin
				fire = !(cmd_q.op_known && (cmd_q.op == bbcd_pkg::OP_SYNC
					|| (cmd_q.op == bbcd_pkg::OP_GET && !hit && !has_free)));
			end else if (state_q == bbcd_pkg::BK_SCAN) begin
				if (sync_q) fire = scan_end || (valid_q[cur] && dirty_q[cur]);
				else if (scan_end) fire = (cmd_q.op == bbcd_pkg::OP_GET);
				else if (cmd_q.op == bbcd_pkg::OP_GET) fire = (ref_q[cur] == 8'd0);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bbcd_pkg::BK_IDLE:  if (cmd_valid) state_d = bbcd_pkg::BK_EXEC;
			bbcd_pkg::BK_EXEC:  if (out_free) begin
				priority if (!cmd_q.op_known) state_d = bbcd_pkg::BK_IDLE;
				else if (cmd_q.op == bbcd_pkg::OP_SYNC) state_d = bbcd_pkg::BK_SCAN;
				else if (cmd_q.op == bbcd_pkg::OP_GET && !hit && !has_free)
					state_d = bbcd_pkg::BK_SCAN;
				else if (cmd_q.op == bbcd_pkg::OP_DISCARD && s_ok) state_d = bbcd_pkg::BK_SCAN;
				else state_d = bbcd_pkg::BK_IDLE;
			end
			bbcd_pkg::BK_SCAN:  if (out_free) begin
				if (sync_q) begin
					if (scan_end) state_d = bbcd_pkg::BK_IDLE;
				end else if (scan_end) begin
					state_d = bbcd_pkg::BK_IDLE;
				end else if (cmd_q.op == bbcd_pkg::OP_DISCARD) begin
					if (cur == rm_slot_q) state_d = bbcd_pkg::BK_SHIFT;
				end else if (ref_q[cur] == 8'd0) begin
					state_d = bbcd_pkg::BK_SHIFT;
				end
			end
			bbcd_pkg::BK_SHIFT: if (idx_q + CW'(1) >= used_q) state_d = bbcd_pkg::BK_IDLE;
			bbcd_pkg::BK_EMIT:  state_d = bbcd_pkg::BK_IDLE;
			default:            state_d = bbcd_pkg::BK_IDLE;
		endcase
	end

	task automatic put(input logic [2:0] s, input logic [3:0] so, input logic wb,
			input logic [15:0] wbb, input logic fl, input logic la);
		st_q <= s; so_q <= so; wb_q <= wb; wbb_q <= wbb;
		fl_q <= fl; la_q <= la;
	endtask

	always_ff @(posedge clk) begin
		if (state_q == bbcd_pkg::BK_IDLE && cmd_valid) cmd_q <= cmd;
		if (state_q == bbcd_pkg::BK_EXEC && out_free) begin
			if (cmd_q.op == bbcd_pkg::OP_GET && !hit && has_free) block_q[free_idx] <= blk;
		end
		if (state_q == bbcd_pkg::BK_SCAN && out_free && !sync_q && !scan_end
				&& cmd_q.op == bbcd_pkg::OP_GET && ref_q[cur] == 8'd0)
			block_q[cur] <= blk;
		if (state_q == bbcd_pkg::BK_EXEC && out_free && cmd_q.op == bbcd_pkg::OP_GET
				&& !hit && has_free)
			order_q[used_q[SW-1:0]] <= free_idx;
		if (state_q == bbcd_pkg::BK_SHIFT) begin
			if (idx_q + CW'(1) >= used_q) order_q[idx_q[SW-1:0]] <= rm_slot_q;
			else order_q[idx_q[SW-1:0]] <= order_q[SW'(idx_q + CW'(1))];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbcd_pkg::BK_IDLE;
			valid_q <= '0; dirty_q <= '0; used_q <= '0;
			for (int i = 0; i < CACHE_SLOTS; i++) ref_q[i] <= 8'd0;
			idx_q <= '0; rm_slot_q <= '0; sync_q <= 1'b0; ov_q <= 1'b0;
			st_q <= '0; so_q <= '0; wb_q <= 1'b0; wbb_q <= '0; fl_q <= 1'b0; la_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q <= fire || (ov_q && !out_ready);
			unique case (state_q)
				bbcd_pkg::BK_EXEC: if (out_free) begin
					idx_q <= '0;
					sync_q <= cmd_q.op_known && cmd_q.op == bbcd_pkg::OP_SYNC;
					if (!cmd_q.op_known) begin
						put(3'(bbcd_pkg::ST_BAD), 4'd0, 1'b0, 16'd0, 1'b0, 1'b1);
					end else unique case (bbcd_pkg::op_t'(cmd_q.op))
						bbcd_pkg::OP_GET: begin
							if (hit) begin
								if (ref_q[hit_idx] == 8'(bbcd_pkg::RefMax))
									put(3'(bbcd_pkg::ST_BAD), 4'(hit_idx), 1'b0, 16'd0, 1'b0, 1'b1);
								else begin
									ref_q[hit_idx] <= ref_q[hit_idx] + 8'd1;
									put(3'(bbcd_pkg::ST_HIT), 4'(hit_idx), 1'b0, 16'd0, 1'b0, 1'b1);
								end
							end else if (has_free) begin
								valid_q[free_idx] <= 1'b1; dirty_q[free_idx] <= 1'b0;
								ref_q[free_idx] <= 8'd1; used_q <= used_q + CW'(1);
								put(3'(bbcd_pkg::ST_MISS), 4'(free_idx), 1'b0, 16'd0, 1'b1, 1'b1);
							end
						end
						bbcd_pkg::OP_RELEASE: begin
							if (s_ok && ref_q[s_idx] != 8'd0) begin
								ref_q[s_idx] <= ref_q[s_idx] - 8'd1;
								put(3'(bbcd_pkg::ST_HIT), cmd_q.slot, 1'b0, 16'd0, 1'b0, 1'b1);
							end else put(3'(bbcd_pkg::ST_BAD), cmd_q.slot, 1'b0, 16'd0, 1'b0, 1'b1);
						end
						bbcd_pkg::OP_DIRTY: begin
							if (s_ok && ref_q[s_idx] != 8'd0) begin
								dirty_q[s_idx] <= 1'b1;
								put(3'(bbcd_pkg::ST_HIT), cmd_q.slot, 1'b0, 16'd0, 1'b0, 1'b1);
							end else put(3'(bbcd_pkg::ST_BAD), cmd_q.slot, 1'b0, 16'd0, 1'b0, 1'b1);
						end
						bbcd_pkg::OP_SYNC: ;
						bbcd_pkg::OP_DISCARD: begin
							if (s_ok) begin
								valid_q[s_idx] <= 1'b0; dirty_q[s_idx] <= 1'b0;
								ref_q[s_idx] <= 8'd0; rm_slot_q <= s_idx;
								put(3'(bbcd_pkg::ST_HIT), cmd_q.slot, 1'b0, 16'd0, 1'b0, 1'b1);
							end else put(3'(bbcd_pkg::ST_BAD), cmd_q.slot, 1'b0, 16'd0, 1'b0, 1'b1);
						end
						default: ;
					endcase
				end
				bbcd_pkg::BK_SCAN: if (out_free) begin
					if (sync_q) begin
						if (scan_end)
							put(3'(bbcd_pkg::ST_DONE), 4'd0, 1'b0, 16'd0, 1'b0, 1'b1);
						else begin
							if (valid_q[cur] && dirty_q[cur]) begin
								dirty_q[cur] <= 1'b0;
								put(3'(bbcd_pkg::ST_WRITEBACK), 4'(cur), 1'b1,
									16'(block_q[cur]), 1'b0, 1'b0);
							end
							idx_q <= idx_q + CW'(1);
						end
					end else if (scan_end) begin
						if (cmd_q.op == bbcd_pkg::OP_GET)
							put(3'(bbcd_pkg::ST_BUSY), 4'd0, 1'b0, 16'd0, 1'b0, 1'b1);
					end else if (cmd_q.op == bbcd_pkg::OP_DISCARD) begin
						if (cur != rm_slot_q) idx_q <= idx_q + CW'(1);
					end else if (ref_q[cur] == 8'd0) begin
						rm_slot_q <= cur;
						dirty_q[cur] <= 1'b0; valid_q[cur] <= 1'b1; ref_q[cur] <= 8'd1;
						put(3'(bbcd_pkg::ST_MISS), 4'(cur), dirty_q[cur],
							dirty_q[cur] ? 16'(block_q[cur]) : 16'd0, 1'b1, 1'b1);
					end else idx_q <= idx_q + CW'(1);
				end
				bbcd_pkg::BK_SHIFT: begin
					idx_q <= idx_q + CW'(1);
					if (cmd_q.op == bbcd_pkg::OP_DISCARD && idx_q + CW'(1) >= used_q)
						used_q <= used_q - CW'(1);
				end
				default: ;
			endcase
		end
	end

	// discard removes without append: the SHIFT pass writes rm_slot_q at the
	// old last position, which is beyond the shrunken used count and unused
endmodule

[tb/block_buffer_cache_directory_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Block buffer cache directory testbench
// Drives get, release, mark dirty, sync, discard and unknown opcodes through
// the request stream. Results are checked field by field against a local
// model of the slot directory with FIFO victim selection.
// ----------------------------------------------------------------------------
module block_buffer_cache_directory_tb;

	localparam int NSLOTS    = bbcd_pkg::CacheSlotsDef;
	localparam int RAND_ITEMS = 40;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [2:0]  status;
		logic [3:0]  slot_out;
		logic        wb;
		logic [15:0] wb_block;
		logic        fill;
		logic        last;
	} result_t;

	typedef struct {
		logic [2:0]  opcode;
		logic [15:0] block_number;
		logic [3:0]  slot;
		bit          typed;
		logic [2:0]  typed_status;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;

	// directory model
	bit          dir_valid [NSLOTS];
	logic [15:0] dir_block [NSLOTS];
	bit          dir_dirty [NSLOTS];
	int          dir_refs  [NSLOTS];
	int          alloc_fifo[$];

	result_t     pending_results[$];
	int          errors;
	int          cycles;
	bit          no_idle;

	block_buffer_cache_directory dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic result_t mk(logic [2:0] st, int s, logic wb, logic [15:0] wbb,
		logic fill, logic last);
		result_t r;
		r.status = st; r.slot_out = s[3:0]; r.wb = wb; r.wb_block = wbb;
		r.fill = fill; r.last = last;
		return r;
	endfunction

	function automatic void fifo_drop(int s);
		foreach (alloc_fifo[i]) begin
			if (alloc_fifo[i] == s) begin
				alloc_fifo.delete(i);
				return;
			end
		end
	endfunction

	// Updates the directory and queues the words this request produces.
	function automatic void predict_directory(logic [2:0] opcode, logic [15:0] blk,
		logic [3:0] s);
		int  sl;
		bit  ok;
		sl = s;
		ok = dir_valid[sl];
		case (opcode)
			bbcd_pkg::OP_GET: begin
				for (int i = 0; i < NSLOTS; i++) begin
					if (dir_valid[i] && dir_block[i] == blk) begin
						if (dir_refs[i] >= bbcd_pkg::RefMax) begin
							pending_results.push_back(mk(bbcd_pkg::ST_BAD, i, 0, 0, 0, 1));
						end else begin
							dir_refs[i]++;
							pending_results.push_back(mk(bbcd_pkg::ST_HIT, i, 0, 0, 0, 1));
						end
						return;
					end
				end
				if (alloc_fifo.size() < NSLOTS) begin
					for (int i = 0; i < NSLOTS; i++) begin
						if (!dir_valid[i]) begin
							dir_valid[i] = 1; dir_block[i] = blk;
							dir_dirty[i] = 0; dir_refs[i] = 1;
							alloc_fifo.push_back(i);
							pending_results.push_back(mk(bbcd_pkg::ST_MISS, i, 0, 0, 1, 1));
							return;
						end
					end
				end
				foreach (alloc_fifo[i]) begin
					int v;
					v = alloc_fifo[i];
					if (dir_refs[v] == 0) begin
						pending_results.push_back(mk(bbcd_pkg::ST_MISS, v, dir_dirty[v],
							dir_dirty[v] ? dir_block[v] : 16'd0, 1, 1));
						dir_dirty[v] = 0;
						alloc_fifo.delete(i);
						alloc_fifo.push_back(v);
						dir_block[v] = blk; dir_refs[v] = 1;
						return;
					end
				end
				pending_results.push_back(mk(bbcd_pkg::ST_BUSY, 0, 0, 0, 0, 1));
			end
			bbcd_pkg::OP_RELEASE, bbcd_pkg::OP_DIRTY: begin
				if (ok && dir_refs[sl] > 0) begin
					if (opcode == bbcd_pkg::OP_RELEASE) dir_refs[sl]--;
					else dir_dirty[sl] = 1;
					pending_results.push_back(mk(bbcd_pkg::ST_HIT, sl, 0, 0, 0, 1));
				end else begin
					pending_results.push_back(mk(bbcd_pkg::ST_BAD, sl, 0, 0, 0, 1));
				end
			end
			bbcd_pkg::OP_SYNC: begin
				foreach (alloc_fifo[i]) begin
					int v;
					v = alloc_fifo[i];
					if (dir_valid[v] && dir_dirty[v]) begin
						dir_dirty[v] = 0;
						pending_results.push_back(mk(bbcd_pkg::ST_WRITEBACK, v, 1,
							dir_block[v], 0, 0));
					end
				end
				pending_results.push_back(mk(bbcd_pkg::ST_DONE, 0, 0, 0, 0, 1));
			end
			bbcd_pkg::OP_DISCARD: begin
				if (ok) begin
					fifo_drop(sl);
					dir_valid[sl] = 0; dir_dirty[sl] = 0; dir_refs[sl] = 0;
					pending_results.push_back(mk(bbcd_pkg::ST_HIT, sl, 0, 0, 0, 1));
				end else begin
					pending_results.push_back(mk(bbcd_pkg::ST_BAD, sl, 0, 0, 0, 1));
				end
			end
			default: pending_results.push_back(mk(bbcd_pkg::ST_BAD, 0, 0, 0, 0, 1));
		endcase
	endfunction

	task automatic sender_idle();
		int n;
		if (no_idle || $urandom_range(0, 3) != 0) return;
		n = $urandom_range(1, 7);
		s_axis_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// returns the status of the first predicted word
	task automatic send_request(logic [2:0] opcode, logic [15:0] blk, logic [3:0] s,
		output logic [2:0] first_status);
		int base_idx;
		sender_idle();
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, s, blk, opcode};
		do @(posedge clk); while (!s_axis_tready);
		base_idx = pending_results.size();
		predict_directory(opcode, blk, s);
		first_status = pending_results[base_idx].status;
	endtask

	task automatic drain(int settle);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// result checker and output stall generator
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result word %h", m_axis_tdata);
					errors++;
				end else begin
					result_t e;
					e = pending_results.pop_front();
					if (m_axis_tdata[2:0] !== e.status) begin
						$error("status exp %0d got %0d", e.status, m_axis_tdata[2:0]);
						errors++;
					end
					if (m_axis_tdata[6:3] !== e.slot_out) begin
						$error("slot_out exp %0d got %0d", e.slot_out, m_axis_tdata[6:3]);
						errors++;
					end
					if (m_axis_tdata[7] !== e.wb) begin
						$error("writeback_needed exp %0d got %0d", e.wb, m_axis_tdata[7]);
						errors++;
					end
					if (m_axis_tdata[23:8] !== e.wb_block) begin
						$error("writeback_block exp %h got %h", e.wb_block,
							m_axis_tdata[23:8]);
						errors++;
					end
					if (m_axis_tdata[24] !== e.fill) begin
						$error("fill_needed exp %0d got %0d", e.fill, m_axis_tdata[24]);
						errors++;
					end
					if (m_axis_tlast !== e.last) begin
						$error("last exp %0d got %0d", e.last, m_axis_tlast);
						errors++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 6);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	row_t directed [19] = '{
		'{bbcd_pkg::OP_RELEASE, 16'h0000, 4'd0,  1, bbcd_pkg::ST_BAD},
		'{bbcd_pkg::OP_DIRTY,   16'h0000, 4'd15, 1, bbcd_pkg::ST_BAD},
		'{bbcd_pkg::OP_DISCARD, 16'h0000, 4'd7,  1, bbcd_pkg::ST_BAD},
		'{bbcd_pkg::OP_SYNC,    16'h0000, 4'd0,  1, bbcd_pkg::ST_DONE},
		'{bbcd_pkg::OP_GET,     16'h0000, 4'd0,  1, bbcd_pkg::ST_MISS},
		'{bbcd_pkg::OP_GET,     16'hFFFF, 4'd15, 1, bbcd_pkg::ST_MISS},
		'{bbcd_pkg::OP_GET,     16'h0000, 4'd0,  1, bbcd_pkg::ST_HIT},
		'{bbcd_pkg::OP_DIRTY,   16'h0000, 4'd0,  0, 3'd0},
		'{bbcd_pkg::OP_DIRTY,   16'h0000, 4'd1,  0, 3'd0},
		'{bbcd_pkg::OP_SYNC,    16'h0000, 4'd0,  0, 3'd0},
		'{bbcd_pkg::OP_DIRTY,   16'h0000, 4'd1,  0, 3'd0},
		'{bbcd_pkg::OP_RELEASE, 16'h0000, 4'd1,  0, 3'd0},
		'{bbcd_pkg::OP_RELEASE, 16'h0000, 4'd1,  1, bbcd_pkg::ST_BAD},
		'{bbcd_pkg::OP_DIRTY,   16'h0000, 4'd1,  1, bbcd_pkg::ST_BAD},
		'{bbcd_pkg::OP_DISCARD, 16'h0000, 4'd1,  1, bbcd_pkg::ST_HIT},
		'{3'd5,                 16'hFFFF, 4'd15, 1, bbcd_pkg::ST_BAD},
		'{3'd6,                 16'h5555, 4'd10, 1, bbcd_pkg::ST_BAD},
		'{3'd7,                 16'hAAAA, 4'd5,  1, bbcd_pkg::ST_BAD},
		'{bbcd_pkg::OP_SYNC,    16'h0000, 4'd0,  0, 3'd0}
	};

	initial begin
		logic [2:0]  st;
		logic [2:0]  opcode;
		logic [15:0] blk;
		int          r;
		errors = 0; cycles = 0; no_idle = 0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_request(directed[i].opcode, directed[i].block_number, directed[i].slot, st);
			if (directed[i].typed && st !== directed[i].typed_status) begin
				$error("row %0d status exp %0d, model gives %0d", i,
					directed[i].typed_status, st);
				errors++;
			end
		end
		drain(2 * NSLOTS + 8);

		// fill every slot, dirty some, keep all referenced: busy case, then evictions
		for (int i = 0; i < NSLOTS + 1; i++)
			send_request(bbcd_pkg::OP_GET, 16'(16'h1000 + i), 4'd0, st);
		for (int i = 0; i < NSLOTS; i += 3)
			send_request(bbcd_pkg::OP_DIRTY, 16'd0, 4'(i), st);
		send_request(bbcd_pkg::OP_GET, 16'h2000, 4'd0, st);
		for (int i = NSLOTS - 1; i >= 0; i -= 2)
			send_request(bbcd_pkg::OP_RELEASE, 16'd0, 4'(i), st);
		for (int i = 0; i < 6; i++)
			send_request(bbcd_pkg::OP_GET, 16'(16'h3000 + i), 4'd0, st);
		send_request(bbcd_pkg::OP_SYNC, 16'd0, 4'd0, st);
		drain(2 * NSLOTS + 8);

		// reference count saturation on one block
		for (int i = 0; i < bbcd_pkg::RefMax + 2; i++) begin
			no_idle = (i % 64) > 40;
			send_request(bbcd_pkg::OP_GET, 16'h1003, 4'd0, st);
		end
		no_idle = 0;
		for (int i = 0; i < NSLOTS; i++)
			send_request(bbcd_pkg::OP_DISCARD, 16'd0, 4'(i), st);
		drain(2 * NSLOTS + 8);

		// random mix over a small block range to force hits and evictions
		for (int i = 0; i < RAND_ITEMS; i++) begin
			no_idle = i > (RAND_ITEMS * 4) / 5;
			r = $urandom_range(0, 99);
			if (r < 40)      opcode = bbcd_pkg::OP_GET;
			else if (r < 62) opcode = bbcd_pkg::OP_RELEASE;
			else if (r < 77) opcode = bbcd_pkg::OP_DIRTY;
			else if (r < 85) opcode = bbcd_pkg::OP_SYNC;
			else if (r < 95) opcode = bbcd_pkg::OP_DISCARD;
			else             opcode = 3'($urandom_range(5, 7));
			blk = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 23));
			send_request(opcode, blk, 4'($urandom_range(0, NSLOTS - 1)), st);
			if (i == RAND_ITEMS / 2) drain(2 * NSLOTS + 8);
		end
		drain(2 * NSLOTS + 8);

		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid === 1'bx) begin
				$error("m_axis_tvalid unknown");
				errors++;
			end
		end
	end

endmodule

[sim.f]
hdl/bbcd_pkg.sv
hdl/bbcd_front.sv
hdl/bbcd_back.sv
hdl/block_buffer_cache_directory.sv
tb/block_buffer_cache_directory_tb.sv
